@@ rtl/core/channel_occupancy_classifier_unit_defines.svh @@
// assertion macros for the channel occupancy classifier
`ifndef CHANNEL_OCCUPANCY_CLASSIFIER_UNIT_DEFINES_SVH
`define CHANNEL_OCCUPANCY_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define COC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("coc assertion failed");
`define COC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("coc forbidden condition seen");
`else
`define COC_ASSERT(label, prop)
`define COC_ASSERT_NEVER(label, expr)
`endif

`endif

@@ rtl/core/coc_pkg.sv @@
package coc_pkg;

    localparam int CNT_W       = 32;
    localparam int CREDIT_W    = 8;
    localparam int PAN_W       = 16;
    localparam int SEQ_W       = 8;
    localparam int RSSI_W      = 5;
    localparam int FC_W        = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CNT     = 6;
    localparam int DEF_SEQ_DEPTH = 4;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int CNT_MEASURE       = 0;
    localparam int CNT_OWN_BUSY      = 1;
    localparam int CNT_OWN_QUIET     = 2;
    localparam int CNT_FOREIGN_BUSY  = 3;
    localparam int CNT_FOREIGN_QUIET = 4;
    localparam int CNT_IDLE_BUSY     = 5;

    localparam logic [FC_W-1:0] FC_ADDR_MASK   = 8'h88;
    localparam logic [FC_W-1:0] FC_ACKREQ_MASK = 8'h61;
    localparam logic [FC_W-1:0] FC_ACK_MASK    = 8'h02;

    localparam logic [CNT_W-1:0]    RST_WINDOW   = 32'd500000;
    localparam logic [PAN_W-1:0]    RST_OWN_PAN  = 16'd16;
    localparam logic [CREDIT_W-1:0] RST_PREAMBLE = 8'd11;
    localparam logic [CREDIT_W-1:0] RST_LONG     = 8'd12;
    localparam logic [CREDIT_W-1:0] RST_SHORT    = 8'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW   = 3'd0,
        REG_OWN_PAN  = 3'd1,
        REG_PREAMBLE = 3'd2,
        REG_LONG     = 3'd3,
        REG_SHORT    = 3'd4
    } reg_idx_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [CNT_W-1:0]    window_length;
        logic [PAN_W-1:0]    own_pan;
        logic [CREDIT_W-1:0] preamble_credit;
        logic [CREDIT_W-1:0] long_credit;
        logic [CREDIT_W-1:0] short_credit;
    } cfg_t;

    // one queued operation for the counter bank
    typedef struct packed {
        logic                hdr;
        logic                rx;
        logic                own;
        logic                busy;
        logic [CREDIT_W-1:0] credit;
    } op_t;

    typedef struct packed {
        kind_t                           kind;
        logic                            own_frame;
        logic [NUM_CNT-1:0][CNT_W-1:0]   cnt;
        logic                            last;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CREDIT_W:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - CREDIT_W){1'b0}}, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/core/coc_queue.sv @@
module coc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  coc_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output coc_pkg::op_t  head
);
    import coc_pkg::*;

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign valid = (fill_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/core/coc_front.sv @@
module coc_front #(
    parameter int SEQ_DEPTH = coc_pkg::DEF_SEQ_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [coc_pkg::CMD_W-1:0]     cmd,
    input  logic [coc_pkg::RSSI_W-1:0]    rssi,
    input  logic [coc_pkg::FC_W-1:0]      fc_low,
    input  logic [coc_pkg::FC_W-1:0]      fc_high,
    input  logic [coc_pkg::PAN_W-1:0]     dest_pan,
    input  logic [coc_pkg::SEQ_W-1:0]     seq_no,
    input  coc_pkg::cfg_t                 cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output coc_pkg::op_t                  q_op
);
    import coc_pkg::*;

    localparam int PW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

    logic             rx_active_reg, rx_active_next;
    logic             own_flag_reg, own_flag_next;
    logic [SEQ_W-1:0] ring_reg [SEQ_DEPTH];
    logic [PW-1:0]    ring_pos_reg, ring_pos_next;

    logic accept;
    logic addressed;
    logic ack_req;
    logic is_ack;
    logic ring_hit;
    logic verdict;
    logic ring_wr;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign addressed = |(fc_high & FC_ADDR_MASK);
    assign ack_req   = |(fc_low & FC_ACKREQ_MASK);
    assign is_ack    = |(fc_low & FC_ACK_MASK);

    always_comb
    begin
        ring_hit = 1'b0;
        for (int i = 0; i < SEQ_DEPTH; i++)
        begin
            if (ring_reg[i] == seq_no)
            begin
                ring_hit = 1'b1;
            end
        end
    end

    assign verdict = addressed ? (dest_pan == cfg.own_pan) : (is_ack && ring_hit);

    always_comb
    begin
        rx_active_next = rx_active_reg;
        own_flag_next  = own_flag_reg;
        ring_pos_next  = ring_pos_reg;
        ring_wr        = 1'b0;
        q_push         = 1'b0;
        q_op.hdr       = 1'b0;
        q_op.rx        = rx_active_reg;
        q_op.own       = own_flag_reg;
        q_op.busy      = |rssi;
        q_op.credit    = '0;
        case (cmd)
            CMD_SAMPLE:
            begin
                q_push = accept;
            end
            CMD_HEADER:
            begin
                q_push      = accept;
                q_op.hdr    = 1'b1;
                q_op.own    = verdict;
                q_op.credit = addressed ? cfg.long_credit : cfg.short_credit;
                if (accept)
                begin
                    rx_active_next = 1'b1;
                    own_flag_next  = verdict;
                    if (addressed && ack_req)
                    begin
                        ring_wr       = 1'b1;
                        ring_pos_next = (ring_pos_reg == PW'(SEQ_DEPTH - 1)) ?
                                        '0 : ring_pos_reg + 1'b1;
                    end
                end
            end
            CMD_END:
            begin
                if (accept)
                begin
                    rx_active_next = 1'b0;
                    own_flag_next  = 1'b0;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_active_reg <= 1'b0;
            own_flag_reg  <= 1'b0;
            ring_pos_reg  <= '0;
            for (int i = 0; i < SEQ_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            rx_active_reg <= rx_active_next;
            own_flag_reg  <= own_flag_next;
            ring_pos_reg  <= ring_pos_next;
            if (ring_wr)
            begin
                ring_reg[ring_pos_reg] <= seq_no;
            end
        end
    end

endmodule

@@ rtl/core/coc_back.sv @@
`include "channel_occupancy_classifier_unit_defines.svh"

module coc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  coc_pkg::op_t  q_op,
    output logic          q_pop,
    input  coc_pkg::cfg_t cfg,
    output logic          out_valid,
    input  logic          out_ready,
    output coc_pkg::res_t res
);
    import coc_pkg::*;

    logic [NUM_CNT-1:0][CNT_W-1:0] cnt_reg, cnt_next, upd;
    logic                          out_valid_reg, out_valid_next;
    logic                          pend_valid_reg, pend_valid_next;
    res_t                          out_res_reg, out_res_next;
    res_t                          pend_res_reg, pend_res_next;

    logic [CREDIT_W:0] hdr_amt;
    logic [CREDIT_W:0] cls_amt;
    logic [CREDIT_W:0] meas_amt;
    logic [CNT_W-1:0]  pre_ext;
    logic              hit_ob, hit_oq, hit_fb, hit_fq, hit_ib;
    logic              report_hit;
    logic              produces;
    logic              out_free;
    res_t              verdict_res;
    res_t              report_res;

    assign hdr_amt  = {1'b0, cfg.preamble_credit} + {1'b0, q_op.credit};
    assign cls_amt  = q_op.hdr ? hdr_amt : (CREDIT_W + 1)'(1);
    assign meas_amt = q_op.hdr ? {1'b0, q_op.credit} : (CREDIT_W + 1)'(1);
    assign pre_ext  = {{(CNT_W - CREDIT_W){1'b0}}, cfg.preamble_credit};

    assign hit_ob = q_op.hdr ? q_op.own  : (q_op.rx && q_op.own && q_op.busy);
    assign hit_oq = !q_op.hdr && q_op.rx && q_op.own && !q_op.busy;
    assign hit_fb = q_op.hdr ? !q_op.own : (q_op.rx && !q_op.own && q_op.busy);
    assign hit_fq = !q_op.hdr && q_op.rx && !q_op.own && !q_op.busy;
    assign hit_ib = !q_op.hdr && !q_op.rx && q_op.busy;

    always_comb
    begin
        upd = cnt_reg;
        upd[CNT_MEASURE] = sat_add(cnt_reg[CNT_MEASURE], meas_amt);
        if (hit_ob)
        begin
            upd[CNT_OWN_BUSY] = sat_add(cnt_reg[CNT_OWN_BUSY], cls_amt);
        end
        if (hit_oq)
        begin
            upd[CNT_OWN_QUIET] = sat_add(cnt_reg[CNT_OWN_QUIET], cls_amt);
        end
        if (hit_fb)
        begin
            upd[CNT_FOREIGN_BUSY] = sat_add(cnt_reg[CNT_FOREIGN_BUSY], cls_amt);
        end
        if (hit_fq)
        begin
            upd[CNT_FOREIGN_QUIET] = sat_add(cnt_reg[CNT_FOREIGN_QUIET], cls_amt);
        end
        // preamble credit moves out of the idle count, clamped at zero
        if (q_op.hdr)
        begin
            upd[CNT_IDLE_BUSY] = (cnt_reg[CNT_IDLE_BUSY] < pre_ext) ?
                                 '0 : cnt_reg[CNT_IDLE_BUSY] - pre_ext;
        end
        else if (hit_ib)
        begin
            upd[CNT_IDLE_BUSY] = sat_add(cnt_reg[CNT_IDLE_BUSY], cls_amt);
        end
    end

    assign report_hit = (upd[CNT_MEASURE] >= cfg.window_length);
    assign produces   = q_op.hdr || report_hit;
    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = q_valid && !pend_valid_reg && (out_free || !produces);

    always_comb
    begin
        verdict_res.kind      = KIND_VERDICT;
        verdict_res.own_frame = q_op.own;
        verdict_res.cnt       = '0;
        verdict_res.last      = !report_hit;
        report_res.kind       = KIND_REPORT;
        report_res.own_frame  = 1'b0;
        report_res.cnt        = upd;
        report_res.last       = 1'b1;
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            cnt_next = report_hit ? '0 : upd;
        end
        if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_res_next    = pend_res_reg;
            pend_valid_next = 1'b0;
        end
        else if (q_pop && q_op.hdr)
        begin
            out_valid_next = 1'b1;
            out_res_next   = verdict_res;
            if (report_hit)
            begin
                pend_valid_next = 1'b1;
                pend_res_next   = report_res;
            end
        end
        else if (q_pop && report_hit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = report_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = out_res_reg;

    // a held report only ever waits behind a verdict of the same header
    `COC_ASSERT(a_pend_behind_verdict, pend_valid_reg |-> out_valid_reg && out_res_reg.kind == KIND_VERDICT && !out_res_reg.last)
    `COC_ASSERT_NEVER(a_pop_with_pend, pend_valid_reg && q_pop)
    `COC_ASSERT(a_window_clears, q_pop && report_hit |=> cnt_reg == '0)

endmodule

@@ rtl/core/channel_occupancy_classifier_unit.sv @@
// channel       direction  handshake              payload
// in            input      in_valid / in_ready    cmd rssi fc_low fc_high dest_pan seq_no
// out           output     out_valid / out_ready  kind own_frame six counters last
// cfg           input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// one input transaction per cycle sustained while the queue is not full; a header that closes a window
// gives two output transactions and holds the counter bank while the second one waits
// a two-entry queue between classifier and counter bank absorbs output stalls
// asynchronous reset clears flags, sequence ring and counters at once, no sweep
// cfg_ready is always high; configuration is taken in any cycle
module channel_occupancy_classifier_unit #(
    parameter int SEQ_DEPTH = coc_pkg::DEF_SEQ_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [coc_pkg::CMD_W-1:0]         cmd,
    input  logic [coc_pkg::RSSI_W-1:0]        rssi,
    input  logic [coc_pkg::FC_W-1:0]          fc_low,
    input  logic [coc_pkg::FC_W-1:0]          fc_high,
    input  logic [coc_pkg::PAN_W-1:0]         dest_pan,
    input  logic [coc_pkg::SEQ_W-1:0]         seq_no,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic                              own_frame,
    output logic [coc_pkg::CNT_W-1:0]         measure_count,
    output logic [coc_pkg::CNT_W-1:0]         own_busy,
    output logic [coc_pkg::CNT_W-1:0]         own_quiet,
    output logic [coc_pkg::CNT_W-1:0]         foreign_busy,
    output logic [coc_pkg::CNT_W-1:0]         foreign_quiet,
    output logic [coc_pkg::CNT_W-1:0]         idle_busy,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [coc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [coc_pkg::CNT_W-1:0]         cfg_data
);
    import coc_pkg::*;

    cfg_t cfg_reg, cfg_next;
    op_t  front_op;
    op_t  head_op;
    res_t res;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW:   cfg_next.window_length   = cfg_data;
                REG_OWN_PAN:  cfg_next.own_pan         = cfg_data[PAN_W-1:0];
                REG_PREAMBLE: cfg_next.preamble_credit = cfg_data[CREDIT_W-1:0];
                REG_LONG:     cfg_next.long_credit     = cfg_data[CREDIT_W-1:0];
                REG_SHORT:    cfg_next.short_credit    = cfg_data[CREDIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length   <= RST_WINDOW;
            cfg_reg.own_pan         <= RST_OWN_PAN;
            cfg_reg.preamble_credit <= RST_PREAMBLE;
            cfg_reg.long_credit     <= RST_LONG;
            cfg_reg.short_credit    <= RST_SHORT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    coc_front #(
        .SEQ_DEPTH (SEQ_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .rssi     (rssi),
        .fc_low   (fc_low),
        .fc_high  (fc_high),
        .dest_pan (dest_pan),
        .seq_no   (seq_no),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    coc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (head_op)
    );

    coc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind          = res.kind;
    assign own_frame     = res.own_frame;
    assign measure_count = res.cnt[CNT_MEASURE];
    assign own_busy      = res.cnt[CNT_OWN_BUSY];
    assign own_quiet     = res.cnt[CNT_OWN_QUIET];
    assign foreign_busy  = res.cnt[CNT_FOREIGN_BUSY];
    assign foreign_quiet = res.cnt[CNT_FOREIGN_QUIET];
    assign idle_busy     = res.cnt[CNT_IDLE_BUSY];
    assign last          = res.last;

endmodule

@@ test/channel_occupancy_classifier_checker.sv @@
module channel_occupancy_classifier_checker
    import coc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [RSSI_W-1:0]    rssi,
    input  logic [FC_W-1:0]      fc_low,
    input  logic [FC_W-1:0]      fc_high,
    input  logic [PAN_W-1:0]     dest_pan,
    input  logic [SEQ_W-1:0]     seq_no,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 kind,
    input  logic                 own_frame,
    input  logic [CNT_W-1:0]     measure_count,
    input  logic [CNT_W-1:0]     own_busy,
    input  logic [CNT_W-1:0]     own_quiet,
    input  logic [CNT_W-1:0]     foreign_busy,
    input  logic [CNT_W-1:0]     foreign_quiet,
    input  logic [CNT_W-1:0]     idle_busy,
    input  logic                 last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CNT_W-1:0]    cfg_window;
    logic [PAN_W-1:0]    cfg_pan;
    logic [CREDIT_W-1:0] cfg_preamble;
    logic [CREDIT_W-1:0] cfg_long;
    logic [CREDIT_W-1:0] cfg_short;

    logic                in_frame;
    logic                frame_is_own;
    logic [SEQ_W-1:0]    acked_seqs [DEF_SEQ_DEPTH];
    int                  acked_pos;
    logic [CNT_W-1:0]    occupancy [NUM_CNT];

    res_t                expected_results [$];
    res_t                oldest;
    int                  mismatch_count = 0;

    logic [NUM_CNT-1:0][CNT_W-1:0] seen_counts;

    string counter_name [NUM_CNT] = '{"measure_count", "own_busy", "own_quiet",
                                      "foreign_busy", "foreign_quiet", "idle_busy"};

    assign seen_counts = {idle_busy, foreign_quiet, foreign_busy,
                          own_quiet, own_busy, measure_count};
    assign mismatches  = mismatch_count;

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void count_up(input int idx, input logic [CNT_W-1:0] amount);
        logic [CNT_W:0] total;
        total = {1'b0, occupancy[idx]} + {1'b0, amount};
        occupancy[idx] = total[CNT_W] ? '1 : total[CNT_W-1:0];
    endfunction

    function automatic logic seq_was_acked(input logic [SEQ_W-1:0] seq);
        for (int i = 0; i < DEF_SEQ_DEPTH; i++)
            if (acked_seqs[i] == seq)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_occupancy(input cmd_t c, input logic [RSSI_W-1:0] r,
                                     input logic [FC_W-1:0] fcl, input logic [FC_W-1:0] fch,
                                     input logic [PAN_W-1:0] pan,
                                     input logic [SEQ_W-1:0] seq);
        res_t                verdict;
        res_t                report;
        logic                own;
        logic [CREDIT_W-1:0] credit;
        bit                  has_verdict;
        bit                  counted;
        verdict     = '0;
        report      = '0;
        has_verdict = 0;
        counted     = 0;
        case (c)
            CMD_SAMPLE:
            begin
                if (in_frame)
                begin
                    if (frame_is_own)
                        count_up(r != '0 ? CNT_OWN_BUSY : CNT_OWN_QUIET, 1);
                    else
                        count_up(r != '0 ? CNT_FOREIGN_BUSY : CNT_FOREIGN_QUIET, 1);
                end
                else if (r != '0)
                    count_up(CNT_IDLE_BUSY, 1);
                count_up(CNT_MEASURE, 1);
                counted = 1;
            end
            CMD_HEADER:
            begin
                if ((fch & FC_ADDR_MASK) != '0)
                begin
                    if ((fcl & FC_ACKREQ_MASK) != '0)
                    begin
                        acked_seqs[acked_pos] = seq;
                        acked_pos = (acked_pos + 1) % DEF_SEQ_DEPTH;
                    end
                    own    = (pan == cfg_pan);
                    credit = cfg_long;
                end
                else
                begin
                    own    = ((fcl & FC_ACK_MASK) != '0) && seq_was_acked(seq);
                    credit = cfg_short;
                end
                // preamble moves from idle to the frame's own class
                count_up(own ? CNT_OWN_BUSY : CNT_FOREIGN_BUSY, CNT_W'(cfg_preamble));
                if (occupancy[CNT_IDLE_BUSY] < CNT_W'(cfg_preamble))
                    occupancy[CNT_IDLE_BUSY] = '0;
                else
                    occupancy[CNT_IDLE_BUSY] -= CNT_W'(cfg_preamble);
                count_up(CNT_MEASURE, CNT_W'(credit));
                count_up(own ? CNT_OWN_BUSY : CNT_FOREIGN_BUSY, CNT_W'(credit));
                in_frame          = 1'b1;
                frame_is_own      = own;
                verdict.kind      = KIND_VERDICT;
                verdict.own_frame = own;
                verdict.last      = 1'b1;
                has_verdict       = 1;
                counted           = 1;
            end
            CMD_END:
            begin
                in_frame     = 1'b0;
                frame_is_own = 1'b0;
            end
            CMD_NONE: ;
        endcase
        if (counted && occupancy[CNT_MEASURE] >= cfg_window)
        begin
            report.kind = KIND_REPORT;
            report.last = 1'b1;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                report.cnt[i] = occupancy[i];
                occupancy[i]  = '0;
            end
            verdict.last = 1'b0;
        end
        if (has_verdict)
            expected_results.push_back(verdict);
        if (report.kind == KIND_REPORT)
            expected_results.push_back(report);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window   = RST_WINDOW;
            cfg_pan      = RST_OWN_PAN;
            cfg_preamble = RST_PREAMBLE;
            cfg_long     = RST_LONG;
            cfg_short    = RST_SHORT;
            in_frame     = 1'b0;
            frame_is_own = 1'b0;
            acked_pos    = 0;
            for (int i = 0; i < DEF_SEQ_DEPTH; i++)
                acked_seqs[i] = '0;
            for (int i = 0; i < NUM_CNT; i++)
                occupancy[i] = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_WINDOW:   cfg_window   = cfg_data;
                    REG_OWN_PAN:  cfg_pan      = cfg_data[PAN_W-1:0];
                    REG_PREAMBLE: cfg_preamble = cfg_data[CREDIT_W-1:0];
                    REG_LONG:     cfg_long     = cfg_data[CREDIT_W-1:0];
                    REG_SHORT:    cfg_short    = cfg_data[CREDIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_occupancy(cmd_t'(cmd), rssi, fc_low, fc_high, dest_pan, seq_no);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none expected, kind", CNT_W'(kind), '0);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (kind !== oldest.kind)
                        report_mismatch("kind", CNT_W'(kind), CNT_W'(oldest.kind));
                    if (own_frame !== oldest.own_frame)
                        report_mismatch("own_frame", CNT_W'(own_frame), CNT_W'(oldest.own_frame));
                    for (int i = 0; i < NUM_CNT; i++)
                        if (seen_counts[i] !== oldest.cnt[i])
                            report_mismatch(counter_name[i], seen_counts[i], oldest.cnt[i]);
                    if (last !== oldest.last)
                        report_mismatch("last", CNT_W'(last), CNT_W'(oldest.last));
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ test/channel_occupancy_classifier_unit_tb.sv @@
module channel_occupancy_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import coc_pkg::*;

    localparam int HALF_PERIOD    = 1;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 10;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd       = '0;
    logic [RSSI_W-1:0]    rssi      = '0;
    logic [FC_W-1:0]      fc_low    = '0;
    logic [FC_W-1:0]      fc_high   = '0;
    logic [PAN_W-1:0]     dest_pan  = '0;
    logic [SEQ_W-1:0]     seq_no    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic                 own_frame;
    logic [CNT_W-1:0]     measure_count;
    logic [CNT_W-1:0]     own_busy;
    logic [CNT_W-1:0]     own_quiet;
    logic [CNT_W-1:0]     foreign_busy;
    logic [CNT_W-1:0]     foreign_quiet;
    logic [CNT_W-1:0]     idle_busy;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    int   items_sent        = 0;
    int   hold_off_requests = 0;
    int   hold_offs_done    = 0;
    int   quiet_cycles      = 0;
    bit   calm              = 0;
    cfg_t cur_cfg;

    channel_occupancy_classifier_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .rssi          (rssi),
        .fc_low        (fc_low),
        .fc_high       (fc_high),
        .dest_pan      (dest_pan),
        .seq_no        (seq_no),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .own_frame     (own_frame),
        .measure_count (measure_count),
        .own_busy      (own_busy),
        .own_quiet     (own_quiet),
        .foreign_busy  (foreign_busy),
        .foreign_quiet (foreign_quiet),
        .idle_busy     (idle_busy),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    channel_occupancy_classifier_checker occupancy_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .rssi          (rssi),
        .fc_low        (fc_low),
        .fc_high       (fc_high),
        .dest_pan      (dest_pan),
        .seq_no        (seq_no),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .own_frame     (own_frame),
        .measure_count (measure_count),
        .own_busy      (own_busy),
        .own_quiet     (own_quiet),
        .foreign_busy  (foreign_busy),
        .foreign_quiet (foreign_quiet),
        .idle_busy     (idle_busy),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL channel_occupancy_classifier_unit");
                $finish;
            end
        end
    end

    // receiver side: random back-pressure, steady ready in calm phases, plus the long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_requests != hold_offs_done)
            begin
                hold_offs_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b0;
                repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(15, 50)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [RSSI_W-1:0] pick_rssi();
        if ($urandom_range(0, 99) < 45)
            return '0;
        return RSSI_W'($urandom_range(1, 31));
    endfunction

    task automatic send_item(input cmd_t c, input logic [RSSI_W-1:0] r,
                             input logic [FC_W-1:0] fcl, input logic [FC_W-1:0] fch,
                             input logic [PAN_W-1:0] pan, input logic [SEQ_W-1:0] seq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        rssi     <= r;
        fc_low   <= fcl;
        fc_high  <= fch;
        dest_pan <= pan;
        seq_no   <= seq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c != CMD_NONE)
            items_sent++;
    endtask

    task automatic send_cmd(input cmd_t c, input logic [RSSI_W-1:0] r);
        send_item(c, r, FC_W'($urandom), FC_W'($urandom), PAN_W'($urandom),
                  SEQ_W'($urandom));
    endtask

    task automatic send_random_header(input bit well_formed);
        logic [FC_W-1:0]  fcl;
        logic [FC_W-1:0]  fch;
        logic [PAN_W-1:0] pan;
        logic [SEQ_W-1:0] seq;
        fcl = FC_W'($urandom);
        fch = FC_W'($urandom);
        pan = PAN_W'($urandom);
        seq = ($urandom_range(0, 9) < 7) ? SEQ_W'($urandom_range(0, 7)) : SEQ_W'($urandom);
        if (well_formed)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if ((fch & FC_ADDR_MASK) == '0)
                        fch = fch | (($urandom_range(0, 1) != 0) ? 8'h08 : 8'h80);
                    if ($urandom_range(0, 3) != 0)
                        fcl = fcl | 8'h20;
                    else
                        fcl = fcl & ~FC_ACKREQ_MASK;
                    if ($urandom_range(0, 2) != 0)
                        pan = cur_cfg.own_pan;
                end
                1:
                begin
                    fch = fch & ~FC_ADDR_MASK;
                    fcl = fcl | FC_ACK_MASK;
                end
                default:
                    fch = fch & ~FC_ADDR_MASK;
            endcase
        end
        send_item(CMD_HEADER, pick_rssi(), fcl, fch, pan, seq);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                begin
                    send_random_header(1);
                    repeat ($urandom_range(0, 12)) send_cmd(CMD_SAMPLE, pick_rssi());
                    if ($urandom_range(0, 9) != 0)
                        send_cmd(CMD_END, pick_rssi());
                    repeat ($urandom_range(0, 5)) send_cmd(CMD_SAMPLE, pick_rssi());
                end
                14, 15, 16:
                    repeat ($urandom_range(1, 10)) send_cmd(CMD_SAMPLE, pick_rssi());
                17:
                    send_cmd(CMD_NONE, RSSI_W'($urandom));
                18:
                    send_cmd(CMD_END, RSSI_W'($urandom));
                default:
                    send_random_header(0);
            endcase
        end
    endtask

    task automatic wait_until_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_WINDOW, c.window_length);
        write_reg(REG_OWN_PAN, CNT_W'(c.own_pan));
        write_reg(REG_PREAMBLE, CNT_W'(c.preamble_credit));
        write_reg(REG_LONG, CNT_W'(c.long_credit));
        write_reg(REG_SHORT, CNT_W'(c.short_credit));
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic run_phase(input cfg_t c, input int count, input bit no_idling);
        wait_until_drained(SETTLE_CYCLES);
        write_config(c);
        calm = no_idling;
        run_random(count);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait_until_drained(SETTLE_CYCLES);
        write_config(cfg_t'{32'd40, 16'h1234, 8'd3, 8'd12, 8'd4});

        send_item(CMD_SAMPLE, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd31, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        // ack against the cleared ring, and idle credit clamps at zero
        send_item(CMD_HEADER, 5'd0, 8'h02, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd31, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_END, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        repeat (4) send_item(CMD_SAMPLE, 5'd1, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_HEADER, 5'd0, 8'h61, 8'h88, 16'h1234, 8'hFF);
        send_item(CMD_SAMPLE, 5'd1, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        // second header with no frame end in between
        send_item(CMD_HEADER, 5'd31, 8'h20, 8'h08, 16'hFFFF, 8'hAB);
        send_item(CMD_SAMPLE, 5'd16, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_END, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_HEADER, 5'd0, 8'h02, 8'h00, 16'h0000, 8'hAB);
        send_item(CMD_HEADER, 5'd0, 8'hFD, 8'h77, 16'h1234, 8'hFF);
        send_item(CMD_NONE, 5'd31, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_END, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_END, 5'd31, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_HEADER, 5'd0, 8'hFF, 8'hFF, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd31, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_SAMPLE, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_END, 5'd0, 8'h00, 8'h00, 16'h0000, 8'h00);

        run_phase(cfg_t'{32'd0, 16'h0000, 8'd0, 8'd0, 8'd0}, 160, 0);
        run_phase(cfg_t'{32'd1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 220, 0);
        run_phase(cfg_t'{32'hFFFF_FFFF, PAN_W'($urandom), CREDIT_W'($urandom),
                         CREDIT_W'($urandom), CREDIT_W'($urandom)}, 260, 0);

        // queue fills behind a stalled receiver, then the sender waits for all results
        run_phase(cfg_t'{CNT_W'($urandom_range(20, 300)), PAN_W'($urandom),
                         CREDIT_W'($urandom), CREDIT_W'($urandom), CREDIT_W'($urandom)},
                  120, 0);
        hold_off_requests++;
        run_random(100);
        wait_until_drained(0);
        run_random(100);

        run_phase(cfg_t'{RST_WINDOW, RST_OWN_PAN, RST_PREAMBLE, RST_LONG, RST_SHORT}, 250, 0);
        run_phase(cfg_t'{CNT_W'($urandom_range(2, 60)), PAN_W'($urandom),
                         CREDIT_W'($urandom), CREDIT_W'($urandom), CREDIT_W'($urandom)},
                  300, 1);
        run_phase(cfg_t'{CNT_W'($urandom_range(50, 2000)), PAN_W'($urandom),
                         CREDIT_W'($urandom), CREDIT_W'($urandom), CREDIT_W'($urandom)},
                  320, 0);

        wait_until_drained(TAIL_CYCLES);
        if (mismatches == 0)
            $display("PASS channel_occupancy_classifier_unit");
        else
            $display("FAIL channel_occupancy_classifier_unit");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/coc_pkg.sv
rtl/core/coc_queue.sv
rtl/core/coc_front.sv
rtl/core/coc_back.sv
rtl/core/channel_occupancy_classifier_unit.sv
test/channel_occupancy_classifier_checker.sv
test/channel_occupancy_classifier_unit_tb.sv
